// File: sv/complex_elementwise_alu_unit_defines.svh
// Assertion macros shared by the complex arithmetic unit.
// Plain text macros only; no dependencies.
`ifndef COMPLEX_ELEMENTWISE_ALU_UNIT_DEFINES_SVH
`define COMPLEX_ELEMENTWISE_ALU_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define CEAU_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define CEAU_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: sv/ceau_pkg.sv
// Shared types and operation codes of the complex arithmetic unit.
// No dependencies.
package ceau_pkg;

   // Operation codes carried in the request tuser field.
   localparam logic [2:0] KIND_ADD   = 3'd0;
   localparam logic [2:0] KIND_SUB   = 3'd1;
   localparam logic [2:0] KIND_MUL   = 3'd2;
   localparam logic [2:0] KIND_DIV   = 3'd3;
   localparam logic [2:0] KIND_RECIP = 3'd4;
   localparam logic [2:0] KIND_NEG   = 3'd5;

   // Per-word control flags that travel down the pipeline beside the data.
   typedef struct packed {
      logic [2:0] kind;
      logic       last;
      logic       a_re_neg;
      logic       a_im_neg;
      logic       zd;
      logic       neg_re;
      logic       neg_im;
      logic       dsat;
      logic       ovf_re;
      logic       ovf_im;
   } ceau_side_type;

   // True for the operations that go through the divider.
   function automatic logic is_quot(input logic [2:0] kind);
      return (kind == KIND_DIV) || (kind == KIND_RECIP);
   endfunction

endpackage

// File: sv/ceau_mul.sv
// Two-stage signed multiplier built from half-width partial products.
// Standalone; used by the complex arithmetic unit top level.
module ceau_mul #(
   parameter int DATA_WIDTH = 32
) (
   input  logic                          clock,
   input  logic                          en,
   input  logic signed [DATA_WIDTH-1:0]  x,
   input  logic signed [DATA_WIDTH-1:0]  y,
   output logic signed [2*DATA_WIDTH-1:0] p
);
   localparam int W  = DATA_WIDTH;
   localparam int H  = W / 2;
   localparam int HW = W - H;
   localparam int PW = 2 * W;

   logic signed [HW-1:0]   xh, yh;
   logic [H-1:0]           xl, yl;
   logic signed [2*HW-1:0] hh_in, hh_ff;
   logic signed [HW+H:0]   hl_in, hl_ff, lh_in, lh_ff;
   logic [2*H-1:0]         ll_in, ll_ff;
   logic signed [PW-1:0]   p_in, p_ff;

   // Split both operands into a signed high half and an unsigned low half.
   assign xh = x[W-1:H];
   assign yh = y[W-1:H];
   assign xl = x[H-1:0];
   assign yl = y[H-1:0];

   // First stage: four partial products.
   assign hh_in = xh * yh;
   assign hl_in = xh * $signed({1'b0, yl});
   assign lh_in = $signed({1'b0, xl}) * yh;
   assign ll_in = xl * yl;

   // Second stage: align and sum the partial products.
   assign p_in = (PW'(hh_ff) <<< (2 * H)) + ((PW'(hl_ff) + PW'(lh_ff)) <<< H)
                 + $signed(PW'(ll_ff));

   always_ff @(posedge clock) begin
      if (en) begin
         hh_ff <= hh_in;
         hl_ff <= hl_in;
         lh_ff <= lh_in;
         ll_ff <= ll_in;
         p_ff  <= p_in;
      end
   end

   assign p = p_ff;

endmodule

// File: sv/ceau_div_step.sv
// One restoring-division stage for the real and imaginary quotients.
// Depends on ceau_pkg for the control flags that ride along.
module ceau_div_step import ceau_pkg::*; #(
   parameter int DATA_WIDTH = 32,
   parameter int STEP       = 0
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       en,
   input  logic                       v_i,
   input  ceau_side_type              side_i,
   input  logic [DATA_WIDTH-1:0]      dre_i,
   input  logic [DATA_WIDTH-1:0]      dim_i,
   input  logic [3*DATA_WIDTH+2:0]    r_re_i,
   input  logic [3*DATA_WIDTH+2:0]    r_im_i,
   input  logic [DATA_WIDTH:0]        q_re_i,
   input  logic [DATA_WIDTH:0]        q_im_i,
   input  logic [2*DATA_WIDTH:0]      dv_i,
   output logic                       v_o,
   output ceau_side_type              side_o,
   output logic [DATA_WIDTH-1:0]      dre_o,
   output logic [DATA_WIDTH-1:0]      dim_o,
   output logic [3*DATA_WIDTH+2:0]    r_re_o,
   output logic [3*DATA_WIDTH+2:0]    r_im_o,
   output logic [DATA_WIDTH:0]        q_re_o,
   output logic [DATA_WIDTH:0]        q_im_o,
   output logic [2*DATA_WIDTH:0]      dv_o
);
   localparam int RW = 3 * DATA_WIDTH + 3;
   localparam int QW = DATA_WIDTH + 1;

   logic [RW-1:0] sub_w;
   logic          ge_re, ge_im;
   logic [RW-1:0] r_re_in, r_im_in;
   logic [QW-1:0] q_re_in, q_im_in;

   logic                  v_ff;
   ceau_side_type         side_ff;
   logic [DATA_WIDTH-1:0] dre_ff, dim_ff;
   logic [RW-1:0]         r_re_ff, r_im_ff;
   logic [QW-1:0]         q_re_ff, q_im_ff;
   logic [2*DATA_WIDTH:0] dv_ff;

   // Trial subtraction of the shifted divisor from each remainder.
   assign sub_w   = RW'(dv_i) << STEP;
   assign ge_re   = r_re_i >= sub_w;
   assign ge_im   = r_im_i >= sub_w;
   assign r_re_in = ge_re ? (r_re_i - sub_w) : r_re_i;
   assign r_im_in = ge_im ? (r_im_i - sub_w) : r_im_i;
   assign q_re_in = q_re_i | (QW'(ge_re) << STEP);
   assign q_im_in = q_im_i | (QW'(ge_im) << STEP);

   // Valid bit is control state and is cleared by reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else if (en) begin
         v_ff <= v_i;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (en) begin
         side_ff <= side_i;
         dre_ff  <= dre_i;
         dim_ff  <= dim_i;
         r_re_ff <= r_re_in;
         r_im_ff <= r_im_in;
         q_re_ff <= q_re_in;
         q_im_ff <= q_im_in;
         dv_ff   <= dv_i;
      end
   end

   assign v_o    = v_ff;
   assign side_o = side_ff;
   assign dre_o  = dre_ff;
   assign dim_o  = dim_ff;
   assign r_re_o = r_re_ff;
   assign r_im_o = r_im_ff;
   assign q_re_o = q_re_ff;
   assign q_im_o = q_im_ff;
   assign dv_o   = dv_ff;

endmodule

// File: sv/complex_elementwise_alu_unit.sv
// Top level of the complex fixed-point arithmetic unit.
// Depends on ceau_pkg, ceau_mul, ceau_div_step and the assertion macro header.
//
//   channel   direction  tdata                      tuser                     tlast
//   req_      in         a_re, a_im, b_re, b_im     kind                      last_in
//   rsp_      out        c_re, c_im                 saturated, zero_divide    last_out
//
// One word is accepted per cycle when the pipeline is not stalled.
// Every word passes through the restoring divider of DATA_WIDTH + 1 stages,
// which produces one quotient bit per stage.
// Reset is synchronous and clears only the valid bits.
// The whole pipeline stalls, input included, only when its last stage holds a word
// and the output register is full and not taken; no stage moves during a stall.
`include "complex_elementwise_alu_unit_defines.svh"

module complex_elementwise_alu_unit import ceau_pkg::*; #(
   parameter int DATA_WIDTH = 32,
   parameter int FRAC_BITS  = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   // a_re, a_im, b_re, b_im from the lowest bit up, zero padded to bytes
   input  logic [((4*DATA_WIDTH+7)/8)*8-1:0]       req_tdata,
   // kind
   input  logic [2:0]                             req_tuser,
   input  logic                                   req_tlast,
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   // c_re, c_im from the lowest bit up, zero padded to bytes
   output logic [((2*DATA_WIDTH+7)/8)*8-1:0]       rsp_tdata,
   // saturated, zero_divide from the lowest bit up
   output logic [1:0]                             rsp_tuser,
   output logic                                   rsp_tlast
);
   localparam int W      = DATA_WIDTH;
   localparam int F      = FRAC_BITS;
   localparam int PW     = 2 * W;
   localparam int SW     = 2 * W + 1;
   localparam int RW     = 3 * W + 3;
   localparam int QW     = W + 1;
   localparam int DVW    = 2 * W + 1;
   localparam int OUT_TW = ((2 * W + 7) / 8) * 8;

   localparam logic [W-1:0]  MAXV = {1'b0, {(W-1){1'b1}}};
   localparam logic [W-1:0]  MINV = {1'b1, {(W-1){1'b0}}};
   localparam logic [SW-1:0] MAXU = {{(W+2){1'b0}}, {(W-1){1'b1}}};
   localparam logic [SW-1:0] MINU = MAXU + 1'b1;
   localparam logic [SW-1:0] HALF = (SW'(1) << F) >> 1;

   // Saturate a (W+1)-bit signed sum; returns {clip, value}.
   function automatic logic [W:0] sat_sum(input logic [W:0] x);
      logic [W:0] r;
      if (!x[W] && x[W-1]) begin
         r = {1'b1, MAXV};
      end else if (x[W] && !x[W-1]) begin
         r = {1'b1, MINV};
      end else begin
         r = {1'b0, x[W-1:0]};
      end
      return r;
   endfunction

   // Saturate a magnitude with a sign; returns {clip, value}.
   function automatic logic [W:0] sat_mag(input logic [SW-1:0] mag, input logic neg);
      logic [W:0] r;
      if (!neg) begin
         if (mag > MAXU) begin
            r = {1'b1, MAXV};
         end else begin
            r = {1'b0, mag[W-1:0]};
         end
      end else if (mag > MINU) begin
         r = {1'b1, MINV};
      end else begin
         r = {1'b0, W'(~mag[W-1:0] + 1'b1)};
      end
      return r;
   endfunction

   logic en;

   // ------------------------------------------------------------------
   // Stage 1: operand split, add/sub/negate, magnitudes of a.
   // ------------------------------------------------------------------
   logic signed [W-1:0] a_re_w, a_im_w, b_re_w, b_im_w, x_re_w, x_im_w;
   logic [W:0]          sum_re_w, sum_im_w, sat_re_w, sat_im_w;
   ceau_side_type       s1_side_in;
   logic [W-1:0]        s1_amre_in, s1_amim_in;

   assign a_re_w = req_tdata[W-1:0];
   assign a_im_w = req_tdata[2*W-1:W];
   assign b_re_w = req_tdata[3*W-1:2*W];
   assign b_im_w = req_tdata[4*W-1:3*W];

   // The squares feed the divisor: b for divide, a for reciprocal.
   assign x_re_w = (req_tuser == KIND_RECIP) ? a_re_w : b_re_w;
   assign x_im_w = (req_tuser == KIND_RECIP) ? a_im_w : b_im_w;

   assign s1_amre_in = a_re_w[W-1] ? (~a_re_w + 1'b1) : a_re_w;
   assign s1_amim_in = a_im_w[W-1] ? (~a_im_w + 1'b1) : a_im_w;

   always_comb begin
      sum_re_w = '0;
      sum_im_w = '0;
      unique case (req_tuser)
         KIND_ADD: begin
            sum_re_w = {a_re_w[W-1], a_re_w} + {b_re_w[W-1], b_re_w};
            sum_im_w = {a_im_w[W-1], a_im_w} + {b_im_w[W-1], b_im_w};
         end
         KIND_SUB: begin
            sum_re_w = {a_re_w[W-1], a_re_w} - {b_re_w[W-1], b_re_w};
            sum_im_w = {a_im_w[W-1], a_im_w} - {b_im_w[W-1], b_im_w};
         end
         KIND_NEG: begin
            sum_re_w = (W+1)'(0) - {a_re_w[W-1], a_re_w};
            sum_im_w = (W+1)'(0) - {a_im_w[W-1], a_im_w};
         end
         default: begin
         end
      endcase
      sat_re_w = sat_sum(sum_re_w);
      sat_im_w = sat_sum(sum_im_w);
      s1_side_in          = '0;
      s1_side_in.kind     = req_tuser;
      s1_side_in.last     = req_tlast;
      s1_side_in.a_re_neg = a_re_w[W-1];
      s1_side_in.a_im_neg = a_im_w[W-1];
      s1_side_in.dsat     = sat_re_w[W] | sat_im_w[W];
   end

   // Six multipliers: four cross products and two squares for the divisor.
   logic signed [PW-1:0] p_rr, p_ii, p_ri, p_ir, p_d0, p_d1;

   ceau_mul #(.DATA_WIDTH(W)) u_mul_rr (.clock(clock), .en(en), .x(a_re_w), .y(b_re_w),
                                        .p(p_rr));
   ceau_mul #(.DATA_WIDTH(W)) u_mul_ii (.clock(clock), .en(en), .x(a_im_w), .y(b_im_w),
                                        .p(p_ii));
   ceau_mul #(.DATA_WIDTH(W)) u_mul_ri (.clock(clock), .en(en), .x(a_re_w), .y(b_im_w),
                                        .p(p_ri));
   ceau_mul #(.DATA_WIDTH(W)) u_mul_ir (.clock(clock), .en(en), .x(a_im_w), .y(b_re_w),
                                        .p(p_ir));
   ceau_mul #(.DATA_WIDTH(W)) u_mul_d0 (.clock(clock), .en(en), .x(x_re_w), .y(x_re_w),
                                        .p(p_d0));
   ceau_mul #(.DATA_WIDTH(W)) u_mul_d1 (.clock(clock), .en(en), .x(x_im_w), .y(x_im_w),
                                        .p(p_d1));

   logic          s1_v_ff, s2_v_ff, s3_v_ff, s4_v_ff, s5_v_ff;
   ceau_side_type s1_side_ff, s2_side_ff, s3_side_ff, s4_side_ff, s5_side_ff;
   logic [W-1:0]  s1_dre_ff, s2_dre_ff, s3_dre_ff, s4_dre_ff, s5_dre_ff;
   logic [W-1:0]  s1_dim_ff, s2_dim_ff, s3_dim_ff, s4_dim_ff, s5_dim_ff;
   logic [W-1:0]  s1_amre_ff, s2_amre_ff, s3_amre_ff;
   logic [W-1:0]  s1_amim_ff, s2_amim_ff, s3_amim_ff;

   // ------------------------------------------------------------------
   // Stage 3: combine products into numerators and the divisor.
   // ------------------------------------------------------------------
   logic [SW-1:0] s3_sre_in, s3_sim_in, s3_sre_ff, s3_sim_ff;
   logic [PW-1:0] s3_den_in, s3_den_ff;

   always_comb begin
      if (s2_side_ff.kind == KIND_MUL) begin
         s3_sre_in = SW'(p_rr) - SW'(p_ii);
         s3_sim_in = SW'(p_ri) + SW'(p_ir);
      end else begin
         s3_sre_in = SW'(p_rr) + SW'(p_ii);
         s3_sim_in = SW'(p_ir) - SW'(p_ri);
      end
   end
   assign s3_den_in = $unsigned(p_d0) + $unsigned(p_d1);

   // ------------------------------------------------------------------
   // Stage 4: multiply rounding, division operands.
   // ------------------------------------------------------------------
   logic [SW-1:0]  abs_re_w, abs_im_w, rnd_re_w, rnd_im_w;
   logic [W:0]     mul_re_w, mul_im_w;
   logic [RW-1:0]  num_re_w, num_im_w;
   ceau_side_type  s4_side_in;
   logic [W-1:0]   s4_dre_in, s4_dim_in;
   logic [RW-1:0]  s4_nre_in, s4_nim_in, s4_nre_ff, s4_nim_ff;
   logic [DVW-1:0] s4_dv_in, s4_dv_ff;

   assign abs_re_w = s3_sre_ff[SW-1] ? (~s3_sre_ff + 1'b1) : s3_sre_ff;
   assign abs_im_w = s3_sim_ff[SW-1] ? (~s3_sim_ff + 1'b1) : s3_sim_ff;
   assign rnd_re_w = (abs_re_w + HALF) >> F;
   assign rnd_im_w = (abs_im_w + HALF) >> F;
   assign mul_re_w = sat_mag(rnd_re_w, s3_sre_ff[SW-1]);
   assign mul_im_w = sat_mag(rnd_im_w, s3_sim_ff[SW-1]);

   always_comb begin
      s4_side_in = s3_side_ff;
      s4_dre_in  = s3_dre_ff;
      s4_dim_in  = s3_dim_ff;
      s4_side_in.zd = (s3_den_ff == '0);
      if (s3_side_ff.kind == KIND_MUL) begin
         s4_dre_in       = mul_re_w[W-1:0];
         s4_dim_in       = mul_im_w[W-1:0];
         s4_side_in.dsat = mul_re_w[W] | mul_im_w[W];
      end
      // Reciprocal numerators are a_re and -a_im scaled by two fraction widths.
      if (s3_side_ff.kind == KIND_RECIP) begin
         num_re_w          = RW'(s3_amre_ff) << (2 * F);
         num_im_w          = RW'(s3_amim_ff) << (2 * F);
         s4_side_in.neg_re = s3_side_ff.a_re_neg;
         s4_side_in.neg_im = !s3_side_ff.a_im_neg;
      end else begin
         num_re_w          = RW'(abs_re_w) << F;
         num_im_w          = RW'(abs_im_w) << F;
         s4_side_in.neg_re = s3_sre_ff[SW-1];
         s4_side_in.neg_im = s3_sim_ff[SW-1];
      end
   end

   // Rounded quotient: floor((2|n| + d) / 2d).
   assign s4_nre_in = (num_re_w << 1) + RW'(s3_den_ff);
   assign s4_nim_in = (num_im_w << 1) + RW'(s3_den_ff);
   assign s4_dv_in  = {s3_den_ff, 1'b0};

   // ------------------------------------------------------------------
   // Stage 5: quotient overflow check against the divider range.
   // ------------------------------------------------------------------
   logic [RW-1:0]  top_w;
   ceau_side_type  s5_side_in;
   logic [RW-1:0]  s5_nre_ff, s5_nim_ff;
   logic [DVW-1:0] s5_dv_ff;

   assign top_w = RW'(s4_dv_ff) << QW;
   always_comb begin
      s5_side_in        = s4_side_ff;
      s5_side_in.ovf_re = s4_nre_ff >= top_w;
      s5_side_in.ovf_im = s4_nim_ff >= top_w;
   end

   // Front stage valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         s3_v_ff <= 1'b0;
         s4_v_ff <= 1'b0;
         s5_v_ff <= 1'b0;
      end else if (en) begin
         s1_v_ff <= req_tvalid;
         s2_v_ff <= s1_v_ff;
         s3_v_ff <= s2_v_ff;
         s4_v_ff <= s3_v_ff;
         s5_v_ff <= s4_v_ff;
      end
   end

   // Front stage payload.
   always_ff @(posedge clock) begin
      if (en) begin
         s1_side_ff <= s1_side_in;
         s1_dre_ff  <= sat_re_w[W-1:0];
         s1_dim_ff  <= sat_im_w[W-1:0];
         s1_amre_ff <= s1_amre_in;
         s1_amim_ff <= s1_amim_in;
         s2_side_ff <= s1_side_ff;
         s2_dre_ff  <= s1_dre_ff;
         s2_dim_ff  <= s1_dim_ff;
         s2_amre_ff <= s1_amre_ff;
         s2_amim_ff <= s1_amim_ff;
         s3_side_ff <= s2_side_ff;
         s3_dre_ff  <= s2_dre_ff;
         s3_dim_ff  <= s2_dim_ff;
         s3_amre_ff <= s2_amre_ff;
         s3_amim_ff <= s2_amim_ff;
         s3_sre_ff  <= s3_sre_in;
         s3_sim_ff  <= s3_sim_in;
         s3_den_ff  <= s3_den_in;
         s4_side_ff <= s4_side_in;
         s4_dre_ff  <= s4_dre_in;
         s4_dim_ff  <= s4_dim_in;
         s4_nre_ff  <= s4_nre_in;
         s4_nim_ff  <= s4_nim_in;
         s4_dv_ff   <= s4_dv_in;
         s5_side_ff <= s5_side_in;
         s5_dre_ff  <= s4_dre_ff;
         s5_dim_ff  <= s4_dim_ff;
         s5_nre_ff  <= s4_nre_ff;
         s5_nim_ff  <= s4_nim_ff;
         s5_dv_ff   <= s4_dv_ff;
      end
   end

   // ------------------------------------------------------------------
   // Divider: one quotient bit per stage, most significant first.
   // ------------------------------------------------------------------
   logic           dv_v   [0:QW];
   ceau_side_type  dv_side[0:QW];
   logic [W-1:0]   dv_dre [0:QW];
   logic [W-1:0]   dv_dim [0:QW];
   logic [RW-1:0]  dv_rre [0:QW];
   logic [RW-1:0]  dv_rim [0:QW];
   logic [QW-1:0]  dv_qre [0:QW];
   logic [QW-1:0]  dv_qim [0:QW];
   logic [DVW-1:0] dv_d   [0:QW];

   assign dv_v[0]    = s5_v_ff;
   assign dv_side[0] = s5_side_ff;
   assign dv_dre[0]  = s5_dre_ff;
   assign dv_dim[0]  = s5_dim_ff;
   assign dv_rre[0]  = s5_nre_ff;
   assign dv_rim[0]  = s5_nim_ff;
   assign dv_qre[0]  = '0;
   assign dv_qim[0]  = '0;
   assign dv_d[0]    = s5_dv_ff;

   for (genvar j = 0; j < QW; j++) begin : g_div
      ceau_div_step #(
         .DATA_WIDTH(W),
         .STEP      (QW - 1 - j)
      ) u_step (
         .clock (clock),
         .reset (reset),
         .en    (en),
         .v_i   (dv_v[j]),
         .side_i(dv_side[j]),
         .dre_i (dv_dre[j]),
         .dim_i (dv_dim[j]),
         .r_re_i(dv_rre[j]),
         .r_im_i(dv_rim[j]),
         .q_re_i(dv_qre[j]),
         .q_im_i(dv_qim[j]),
         .dv_i  (dv_d[j]),
         .v_o   (dv_v[j+1]),
         .side_o(dv_side[j+1]),
         .dre_o (dv_dre[j+1]),
         .dim_o (dv_dim[j+1]),
         .r_re_o(dv_rre[j+1]),
         .r_im_o(dv_rim[j+1]),
         .q_re_o(dv_qre[j+1]),
         .q_im_o(dv_qim[j+1]),
         .dv_o  (dv_d[j+1])
      );
   end

   // ------------------------------------------------------------------
   // Final selection and the output register.
   // ------------------------------------------------------------------
   logic          fin_v;
   ceau_side_type fin_side;
   logic [W:0]    qs_re_w, qs_im_w;
   logic [W-1:0]  fin_re, fin_im;
   logic          fin_sat, fin_zd;

   assign fin_v    = dv_v[QW];
   assign fin_side = dv_side[QW];
   assign qs_re_w  = sat_mag(SW'(dv_qre[QW]), fin_side.neg_re);
   assign qs_im_w  = sat_mag(SW'(dv_qim[QW]), fin_side.neg_im);

   always_comb begin
      fin_re  = dv_dre[QW];
      fin_im  = dv_dim[QW];
      fin_sat = fin_side.dsat;
      fin_zd  = 1'b0;
      if (is_quot(fin_side.kind)) begin
         if (fin_side.zd) begin
            // Zero divisor: saturate toward the sign of a for divide.
            fin_zd  = 1'b1;
            fin_sat = 1'b1;
            fin_re  = (fin_side.kind == KIND_DIV && fin_side.a_re_neg) ? MINV : MAXV;
            fin_im  = (fin_side.kind == KIND_DIV && fin_side.a_im_neg) ? MINV : MAXV;
         end else begin
            fin_re  = fin_side.ovf_re ? (fin_side.neg_re ? MINV : MAXV) : qs_re_w[W-1:0];
            fin_im  = fin_side.ovf_im ? (fin_side.neg_im ? MINV : MAXV) : qs_im_w[W-1:0];
            fin_sat = fin_side.ovf_re | fin_side.ovf_im | qs_re_w[W] | qs_im_w[W];
         end
      end
   end

   logic         out_valid_ff;
   logic [W-1:0] out_re_ff, out_im_ff;
   logic         out_sat_ff, out_zd_ff, out_last_ff;
   logic         out_load;

   // The pipeline moves unless its last word is blocked by a held output.
   assign out_load   = !out_valid_ff || rsp_tready;
   assign en         = !fin_v || out_load;
   assign req_tready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_load) begin
         out_valid_ff <= fin_v;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load && fin_v) begin
         out_re_ff   <= fin_re;
         out_im_ff   <= fin_im;
         out_sat_ff  <= fin_sat;
         out_zd_ff   <= fin_zd;
         out_last_ff <= fin_side.last;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = OUT_TW'({out_im_ff, out_re_ff});
   assign rsp_tuser  = {out_zd_ff, out_sat_ff};
   assign rsp_tlast  = out_last_ff;

   // ------------------------------------------------------------------
   // Assertions.
   // ------------------------------------------------------------------
   `CEAU_ASSERT_IMPLY(a_zd_sat, clock, reset, rsp_tvalid && rsp_tuser[1], rsp_tuser[0], "zero divide without saturation flag")
   `CEAU_ASSERT_NEXT(a_hold_end, clock, reset, fin_v && !en, fin_v, "stalled word lost at pipeline end")
   `CEAU_ASSERT_IMPLY(a_ready_free, clock, reset, !out_valid_ff, req_tready, "input blocked with empty output")
   `CEAU_ASSERT_IMPLY(a_zd_kind, clock, reset, fin_v && fin_zd, fin_side.kind == KIND_DIV || fin_side.kind == KIND_RECIP, "zero divide on a non-dividing operation")

endmodule

// File: dv/complex_elementwise_alu_unit_tb.sv
// Self-checking testbench for the complex fixed-point arithmetic unit.
// Depends on ceau_pkg and complex_elementwise_alu_unit; predicts each result word
// with wide signed arithmetic and compares it field by field.
`timescale 1ns / 1ps

module complex_elementwise_alu_unit_tb import ceau_pkg::*; ();

   localparam int DW = 32;
   localparam int FB = 16;
   localparam int LATENCY = DW + 7;
   localparam longint CYCLE_LIMIT = 400000;
   localparam logic signed [31:0] VMAX = 32'sh7fffffff;
   localparam logic signed [31:0] VMIN = 32'sh80000000;
   localparam logic [2:0] KIND_BAD6 = 3'd6;
   localparam logic [2:0] KIND_BAD7 = 3'd7;

   typedef struct packed {
      logic [31:0] c_re;
      logic [31:0] c_im;
      logic        sat;
      logic        zdiv;
      logic        last;
   } result_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [127:0] req_tdata = '0;
   logic [2:0] req_tuser = '0;
   logic req_tlast = 1'b0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;
   logic [1:0] rsp_tuser;
   logic rsp_tlast;

   result_word_type expected_q[$];
   int error_count = 0;
   int words_sent = 0;
   int words_checked = 0;
   bit idle_enable = 1'b1;
   int hold_cycles = 0;
   longint cycle_count = 0;

   complex_elementwise_alu_unit #(.DATA_WIDTH(DW), .FRAC_BITS(FB)) u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .req_tuser(req_tuser), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Clip a wide value to the 32-bit signed range.
   function automatic logic [31:0] clip32(input logic signed [199:0] v, inout logic sat);
      if (v > VMAX) begin
         sat = 1'b1;
         return VMAX;
      end
      if (v < VMIN) begin
         sat = 1'b1;
         return VMIN;
      end
      return v[31:0];
   endfunction

   // Divide rounding to nearest, ties away from zero; den is positive.
   function automatic logic signed [199:0] round_quot(input logic signed [199:0] num,
                                                       input logic signed [199:0] den);
      logic signed [199:0] mag;
      logic signed [199:0] q;
      mag = (num < 0) ? -num : num;
      q = (2 * mag + den) / (2 * den);
      return (num < 0) ? -q : q;
   endfunction

   // Drop the fraction bits of a product, to nearest, ties away from zero.
   function automatic logic signed [199:0] round_frac(input logic signed [199:0] p);
      logic signed [199:0] mag;
      mag = (p < 0) ? -p : p;
      mag = (mag + (200'sd1 <<< (FB - 1))) >>> FB;
      return (p < 0) ? -mag : mag;
   endfunction

   // Compute the expected result word for one operand pair.
   function automatic result_word_type complex_result(input logic [2:0] kind,
         input logic signed [31:0] ar, input logic signed [31:0] ai,
         input logic signed [31:0] br, input logic signed [31:0] bi, input logic last);
      result_word_type r;
      logic signed [199:0] wr, wi, xr, xi, yr, yi, den;
      logic sat;
      logic zdiv;
      bit used;
      xr = ar; xi = ai; yr = br; yi = bi;
      wr = 0; wi = 0; sat = 1'b0; zdiv = 1'b0; used = 1'b1;
      case (kind)
         KIND_ADD: begin
            wr = xr + yr; wi = xi + yi;
         end
         KIND_SUB: begin
            wr = xr - yr; wi = xi - yi;
         end
         KIND_MUL: begin
            wr = round_frac(xr * yr - xi * yi);
            wi = round_frac(xr * yi + xi * yr);
         end
         KIND_DIV: begin
            den = yr * yr + yi * yi;
            if (den == 0) begin
               zdiv = 1'b1;
               wr = (ar < 0) ? VMIN : VMAX;
               wi = (ai < 0) ? VMIN : VMAX;
            end else begin
               wr = round_quot((xr * yr + xi * yi) <<< FB, den);
               wi = round_quot((xi * yr - xr * yi) <<< FB, den);
            end
         end
         KIND_RECIP: begin
            den = xr * xr + xi * xi;
            if (den == 0) begin
               zdiv = 1'b1;
               wr = VMAX; wi = VMAX;
            end else begin
               wr = round_quot(xr <<< (2 * FB), den);
               wi = round_quot((-xi) <<< (2 * FB), den);
            end
         end
         KIND_NEG: begin
            wr = -xr; wi = -xi;
         end
         default: used = 1'b0;
      endcase
      r.c_re = '0;
      r.c_im = '0;
      if (used) begin
         r.c_re = clip32(wr, sat);
         r.c_im = clip32(wi, sat);
      end
      r.sat = sat | zdiv;
      r.zdiv = zdiv;
      r.last = last;
      return r;
   endfunction

   // Offer one word, record its expectation and wait for the handshake.
   // The valid line stays high after the handshake; an idle gap or a drain drops it.
   task automatic send_word(input logic [2:0] kind, input logic [31:0] ar,
         input logic [31:0] ai, input logic [31:0] br, input logic [31:0] bi,
         input logic last);
      int gap;
      if (idle_enable && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 7);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= kind;
      req_tdata <= {bi, br, ai, ar};
      req_tlast <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      expected_q.push_back(complex_result(kind, ar, ai, br, bi, last));
      words_sent++;
   endtask

   function automatic logic [31:0] rand_value();
      case ($urandom_range(0, 7))
         0: return VMAX;
         1: return VMIN;
         2: return '0;
         3: return $urandom_range(0, 1) ? 32'h0001_0000 : 32'hffff_0000;
         4: return $signed($urandom_range(0, 16'hffff)) - 32'sd32768;
         5: return {{12{$urandom_range(0, 1) == 1}}, 20'($urandom)};
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [2:0] rand_kind();
      return ($urandom_range(0, 19) == 0) ? 3'($urandom_range(6, 7))
                                          : 3'($urandom_range(0, 5));
   endfunction

   // Stop offering words and wait until every expected result has come.
   task automatic drain_results();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (expected_q.size() != 0);
   endtask

   // Extremes, every operation, unused codes, zero divisors, negating the smallest value.
   task automatic test_directed();
      logic [2:0] k;
      for (int i = 0; i <= 5; i++) begin
         k = 3'(i);
         send_word(k, VMAX, VMIN, VMAX, VMIN, 1'b0);
         send_word(k, 32'h0001_8000, 32'hfffe_8000, 32'h0000_8000, 32'h0002_0000, 1'b1);
      end
      send_word(KIND_DIV, 32'h0001_0000, 32'hffff_0000, '0, '0, 1'b0);
      send_word(KIND_DIV, '0, 32'h8000_0000, '0, '0, 1'b1);
      send_word(KIND_RECIP, '0, '0, 32'h1234, 32'h5678, 1'b0);
      send_word(KIND_RECIP, 32'h0000_0001, '0, '0, '0, 1'b0);
      send_word(KIND_NEG, VMIN, VMIN, '0, '0, 1'b1);
      send_word(KIND_MUL, 32'h0000_0001, 32'h0000_0000, 32'h0000_8000, '0, 1'b0);
      send_word(KIND_MUL, 32'hffff_ffff, '0, 32'h0000_8000, '0, 1'b0);
      send_word(KIND_BAD6, VMAX, VMAX, VMAX, VMAX, 1'b1);
      send_word(KIND_BAD7, VMIN, '1, '1, '1, 1'b0);
      send_word(KIND_DIV, VMIN, VMIN, 32'h0000_0001, '0, 1'b1);
   endtask

   task automatic test_random(input int count);
      for (int i = 0; i < count; i++)
         send_word(rand_kind(), rand_value(), rand_value(), rand_value(), rand_value(),
                   $urandom_range(0, 1));
   endtask

   // Receiver holds off long enough for the pipeline to fill and stall input.
   task automatic test_backpressure();
      hold_cycles = 3 * LATENCY;
      test_random(2 * LATENCY);
      drain_results();
   endtask

   // Result side: random ready bursts and the long hold-off.
   initial begin
      int burst;
      @(negedge reset);
      forever begin
         if (hold_cycles > 0) begin
            rsp_tready <= 1'b0;
            repeat (hold_cycles) @(posedge clock);
            hold_cycles = 0;
         end else if (idle_enable && $urandom_range(0, 4) == 0) begin
            burst = $urandom_range(1, 7);
            rsp_tready <= 1'b0;
            repeat (burst) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   // Check each accepted result word against the oldest expectation.
   always @(posedge clock) begin
      result_word_type exp_w;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_q.size() == 0) begin
            $display("%0t: unexpected result word re=%h im=%h", $time,
                     rsp_tdata[31:0], rsp_tdata[63:32]);
            error_count++;
         end else begin
            exp_w = expected_q.pop_front();
            words_checked++;
            if (rsp_tdata[31:0] !== exp_w.c_re || rsp_tdata[63:32] !== exp_w.c_im ||
                rsp_tuser[0] !== exp_w.sat || rsp_tuser[1] !== exp_w.zdiv ||
                rsp_tlast !== exp_w.last) begin
               $display("%0t: mismatch expected re=%h im=%h sat=%b zd=%b last=%b",
                        $time, exp_w.c_re, exp_w.c_im, exp_w.sat, exp_w.zdiv, exp_w.last);
               $display("%0t:          actual   re=%h im=%h sat=%b zd=%b last=%b",
                        $time, rsp_tdata[31:0], rsp_tdata[63:32], rsp_tuser[0],
                        rsp_tuser[1], rsp_tlast);
               error_count++;
            end
         end
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycle_count);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(300);
      // Sender pauses until every result is back.
      drain_results();
      test_backpressure();
      test_random(300);
      idle_enable = 1'b0;
      test_random(120);
      drain_results();
      repeat (LATENCY + 10) @(posedge clock);
      $display("Sent %0d words over all six operations, unused codes and zero divisors;",
               words_sent);
      $display("checked %0d result words under random and long output stalls.",
               words_checked);
      if (error_count == 0 && expected_q.size() == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
